FILE: design/hca_pkg.sv
// ----------------------------------------------------------------------------
// hca_pkg: shared types and constants for the HSV color adjust pipeline
// Fixed-point formats, divider state, configuration codes and stage structs.
// ----------------------------------------------------------------------------
package hca_pkg;

  localparam int unsigned NUM_STAGES  = 10;
  localparam int unsigned DIV_STAGES  = 4;
  localparam int unsigned DIV_STEPS   = 4;
  localparam int unsigned BACK_STAGES = 5;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HUE_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_GAIN   = 8'd2;

  localparam logic [15:0] HUE_OFFSET_RST = 16'd0;
  localparam logic [15:0] GAIN_UNITY     = 16'd4096;

  // 1.0 in Q0.16 with a 17-bit magnitude
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [15:0] hue_offset;
    logic [15:0] sat_gain;
    logic [15:0] val_gain;
  } hca_cfg_t;

  // restoring divider state: remainder, partial quotient, divisor
  typedef struct packed {
    logic [10:0] rem;
    logic [16:0] quot;
    logic [10:0] den;
  } hca_div_t;

  typedef struct packed {
    hca_div_t    sat;
    hca_div_t    hue;
    logic [16:0] val;
    logic [7:0]  alpha;
    logic        last;
  } hca_mid_t;

endpackage

FILE: design/hca_if.sv
// ----------------------------------------------------------------------------
// hca_if: stream and configuration channels of the HSV color adjust block
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface hca_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  logic       last_pixel;
  modport source (output valid, red_in, green_in, blue_in, alpha_in, last_pixel,
                  input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, last_pixel,
                  output ready);
endinterface

interface hca_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       last_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, last_out,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_out,
                  output ready);
endinterface

interface hca_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hca_pkg::CFG_IDX_W-1:0]  index;
  logic [hca_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/hca_front.sv
// ----------------------------------------------------------------------------
// hca_front: first pipeline stage
// Finds max/min, value, divider operands and the first quotient bit.
// ----------------------------------------------------------------------------
module hca_front (
  input  logic             clk,
  input  logic             load,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  input  logic [7:0]       alpha,
  input  logic             last,
  output hca_pkg::hca_mid_t mid
);

  logic [7:0]  mx, mn, d;
  logic [10:0] d11, d6, hn, hd, sn, sd;
  logic        sge, hge;
  hca_pkg::hca_mid_t mid_nxt, mid_r;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d   = mx - mn;
    d11 = {3'b000, d};
    d6  = {d11[8:0], 2'b00} + {d11[9:0], 1'b0};

    // ties: red beats green, green beats blue
    if (mx == red) begin
      if (green >= blue) hn = {3'b000, green - blue};
      else hn = d6 - {3'b000, blue - green};
    end else if (mx == green) begin
      hn = {d11[9:0], 1'b0} + {3'b000, blue} - {3'b000, red};
    end else begin
      hn = {d11[8:0], 2'b00} + {3'b000, red} - {3'b000, green};
    end
    hd = d6;
    if (d == 8'd0) begin
      hn = 11'd0;
      hd = 11'd1;
    end

    sn = d11;
    sd = {3'b000, mx};
    if (mx == 8'd0) begin
      sn = 11'd0;
      sd = 11'd1;
    end

    sge = (sn >= sd);
    hge = (hn >= hd);
    mid_nxt.sat.rem  = sge ? sn - sd : sn;
    mid_nxt.sat.quot = {16'd0, sge};
    mid_nxt.sat.den  = sd;
    mid_nxt.hue.rem  = hge ? hn - hd : hn;
    mid_nxt.hue.quot = {16'd0, hge};
    mid_nxt.hue.den  = hd;
    // ceil(mx * 65536 / 255) = mx * 257 + (mx != 0)
    mid_nxt.val   = {1'b0, mx, mx} + {16'd0, mx != 8'd0};
    mid_nxt.alpha = alpha;
    mid_nxt.last  = last;
  end

  always_ff @(posedge clk) begin
    if (load) mid_r <= mid_nxt;
  end

  assign mid = mid_r;

endmodule

FILE: design/hca_div_stage.sv
// ----------------------------------------------------------------------------
// hca_div_stage: one stage of the pipelined restoring dividers
// Retires four quotient bits of both the saturation and hue divisions.
// ----------------------------------------------------------------------------
module hca_div_stage (
  input  logic              clk,
  input  logic              load,
  input  hca_pkg::hca_mid_t mid_in,
  output hca_pkg::hca_mid_t mid_out
);

  hca_pkg::hca_mid_t mid_nxt, mid_r;

  function automatic hca_pkg::hca_div_t div_steps(input hca_pkg::hca_div_t s);
    hca_pkg::hca_div_t w;
    logic [11:0]       t;
    w = s;
    for (int k = 0; k < hca_pkg::DIV_STEPS; k++) begin
      t = {w.rem, 1'b0};
      if (t >= {1'b0, w.den}) begin
        w.rem  = 11'(t - {1'b0, w.den});
        w.quot = {w.quot[15:0], 1'b1};
      end else begin
        w.rem  = t[10:0];
        w.quot = {w.quot[15:0], 1'b0};
      end
    end
    return w;
  endfunction

  always_comb begin
    mid_nxt     = mid_in;
    mid_nxt.sat = div_steps(mid_in.sat);
    mid_nxt.hue = div_steps(mid_in.hue);
  end

  always_ff @(posedge clk) begin
    if (load) mid_r <= mid_nxt;
  end

  assign mid_out = mid_r;

endmodule

FILE: design/hca_back.sv
// ----------------------------------------------------------------------------
// hca_back: HSV adjust and HSV-to-RGB stages
// Hue shift, gain with clamp, chroma, sector blend and byte conversion.
// ----------------------------------------------------------------------------
module hca_back (
  input  logic                           clk,
  input  logic [hca_pkg::BACK_STAGES-1:0] load,
  input  hca_pkg::hca_cfg_t              cfg,
  input  hca_pkg::hca_mid_t              mid,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic [7:0]                     alpha,
  output logic                           last
);

  // stage F
  logic [15:0] f_h_r;
  logic [32:0] f_ps_r, f_pv_r;
  logic [7:0]  f_a_r;
  logic        f_l_r;
  // stage G
  logic [15:0] g_h_r;
  logic [16:0] g_s_r, g_v_r, g_s_nxt, g_v_nxt;
  logic [7:0]  g_a_r;
  logic        g_l_r;
  // stage H
  logic [16:0] h_c_r, h_v_r;
  logic [2:0]  h_sec_r;
  logic [15:0] h_f_r;
  logic [7:0]  h_a_r;
  logic        h_l_r;
  logic [33:0] h_cp;
  logic [18:0] h_p;
  // stage I
  logic [16:0] i_x_r, i_c_r, i_m_r, i_fx;
  logic [33:0] i_xp;
  logic [2:0]  i_sec_r;
  logic [7:0]  i_a_r;
  logic        i_l_r;
  // stage J
  logic [16:0] j_q0, j_q1, j_q2;
  logic [7:0]  j_r_r, j_g_r, j_b_r, j_a_r, j_r_nxt, j_g_nxt, j_b_nxt;
  logic        j_l_r;

  function automatic logic [7:0] to_byte(input logic [16:0] q);
    logic [24:0] p;
    p = {q, 8'd0} - {8'd0, q};
    return p[23:16];
  endfunction

  always_ff @(posedge clk) begin
    if (load[0]) begin
      f_h_r  <= mid.hue.quot[15:0] + cfg.hue_offset;
      f_ps_r <= mid.sat.quot * cfg.sat_gain;
      f_pv_r <= mid.val * cfg.val_gain;
      f_a_r  <= mid.alpha;
      f_l_r  <= mid.last;
    end
  end

  always_comb begin
    g_s_nxt = (f_ps_r[32:12] > {4'd0, hca_pkg::ONE_Q16}) ? hca_pkg::ONE_Q16 : f_ps_r[28:12];
    g_v_nxt = (f_pv_r[32:12] > {4'd0, hca_pkg::ONE_Q16}) ? hca_pkg::ONE_Q16 : f_pv_r[28:12];
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      g_h_r <= f_h_r;
      g_s_r <= g_s_nxt;
      g_v_r <= g_v_nxt;
      g_a_r <= f_a_r;
      g_l_r <= f_l_r;
    end
  end

  assign h_cp = g_v_r * g_s_r;
  assign h_p  = {1'b0, g_h_r, 2'b00} + {2'b00, g_h_r, 1'b0};

  always_ff @(posedge clk) begin
    if (load[2]) begin
      h_c_r   <= h_cp[32:16];
      h_v_r   <= g_v_r;
      h_sec_r <= h_p[18:16];
      h_f_r   <= h_p[15:0];
      h_a_r   <= g_a_r;
      h_l_r   <= g_l_r;
    end
  end

  // falling edge of the sector uses 1 - F
  assign i_fx = h_sec_r[0] ? hca_pkg::ONE_Q16 - {1'b0, h_f_r} : {1'b0, h_f_r};
  assign i_xp = h_c_r * i_fx;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      i_x_r   <= i_xp[32:16];
      i_c_r   <= h_c_r;
      i_m_r   <= h_v_r - h_c_r;
      i_sec_r <= h_sec_r;
      i_a_r   <= h_a_r;
      i_l_r   <= h_l_r;
    end
  end

  always_comb begin
    case (i_sec_r)
      3'd0: begin j_q0 = i_c_r; j_q1 = i_x_r; j_q2 = 17'd0; end
      3'd1: begin j_q0 = i_x_r; j_q1 = i_c_r; j_q2 = 17'd0; end
      3'd2: begin j_q0 = 17'd0; j_q1 = i_c_r; j_q2 = i_x_r; end
      3'd3: begin j_q0 = 17'd0; j_q1 = i_x_r; j_q2 = i_c_r; end
      3'd4: begin j_q0 = i_x_r; j_q1 = 17'd0; j_q2 = i_c_r; end
      default: begin j_q0 = i_c_r; j_q1 = 17'd0; j_q2 = i_x_r; end
    endcase
    j_r_nxt = to_byte(j_q0 + i_m_r);
    j_g_nxt = to_byte(j_q1 + i_m_r);
    j_b_nxt = to_byte(j_q2 + i_m_r);
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      j_r_r <= j_r_nxt;
      j_g_r <= j_g_nxt;
      j_b_r <= j_b_nxt;
      j_a_r <= i_a_r;
      j_l_r <= i_l_r;
    end
  end

  assign red   = j_r_r;
  assign green = j_g_r;
  assign blue  = j_b_r;
  assign alpha = j_a_r;
  assign last  = j_l_r;

endmodule

FILE: design/hsv_color_adjust.sv
// ----------------------------------------------------------------------------
// hsv_color_adjust: RGBA pixel adjustment in HSV space
// Ten-stage pipeline: hue shift, saturation and value gains, back to RGB.
// ----------------------------------------------------------------------------
// The block takes one RGBA pixel per clock and returns one adjusted pixel
// per clock while the output is not stalled, with alpha and the
// last-pixel mark carried along. Stage one finds max, min and value; four
// divider stages resolve saturation and hue at four quotient bits each;
// five stages shift hue, apply the gains with a clamp at 1.0 and rebuild
// RGB. Every stage holds its own valid bit, so a stall at the output fills
// empty slots first and the input keeps accepting until the pipe is full.
// Configuration writes are always accepted and should be issued only
// while no pixel is in flight.
// ----------------------------------------------------------------------------
module hsv_color_adjust (
  input logic          clk,
  input logic          rst_n,
  hca_pix_in_if.sink   in_ch,
  hca_pix_out_if.source out_ch,
  hca_cfg_if.sink      cfg_ch
);

  logic [hca_pkg::NUM_STAGES-1:0] v_r, v_nxt, load;
  hca_pkg::hca_cfg_t cfg_r, cfg_nxt;
  hca_pkg::hca_mid_t mid [hca_pkg::DIV_STAGES+1];

  // Configuration registers: ignore writes beyond the last index.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        hca_pkg::CFG_HUE_OFFSET: cfg_nxt.hue_offset = cfg_ch.data;
        hca_pkg::CFG_SAT_GAIN:   cfg_nxt.sat_gain   = cfg_ch.data;
        hca_pkg::CFG_VAL_GAIN:   cfg_nxt.val_gain   = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_offset <= hca_pkg::HUE_OFFSET_RST;
      cfg_r.sat_gain   <= hca_pkg::GAIN_UNITY;
      cfg_r.val_gain   <= hca_pkg::GAIN_UNITY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A stage loads when it is empty or its content advances downstream.
  always_comb begin
    load[hca_pkg::NUM_STAGES-1] = !v_r[hca_pkg::NUM_STAGES-1] || out_ch.ready;
    for (int i = hca_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = !v_r[i] || load[i+1];
    end
    v_nxt = v_r;
    if (load[0]) v_nxt[0] = in_ch.valid;
    for (int i = 1; i < hca_pkg::NUM_STAGES; i++) begin
      if (load[i]) v_nxt[i] = v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = load[0];
  assign out_ch.valid = v_r[hca_pkg::NUM_STAGES-1];

  hca_front u_front (
    .clk   (clk),
    .load  (load[0]),
    .red   (in_ch.red_in),
    .green (in_ch.green_in),
    .blue  (in_ch.blue_in),
    .alpha (in_ch.alpha_in),
    .last  (in_ch.last_pixel),
    .mid   (mid[0])
  );

  for (genvar s = 0; s < hca_pkg::DIV_STAGES; s++) begin : g_div
    hca_div_stage u_div (
      .clk     (clk),
      .load    (load[s+1]),
      .mid_in  (mid[s]),
      .mid_out (mid[s+1])
    );
  end

  hca_back u_back (
    .clk   (clk),
    .load  (load[hca_pkg::NUM_STAGES-1:hca_pkg::DIV_STAGES+1]),
    .cfg   (cfg_r),
    .mid   (mid[hca_pkg::DIV_STAGES]),
    .red   (out_ch.red_out),
    .green (out_ch.green_out),
    .blue  (out_ch.blue_out),
    .alpha (out_ch.alpha_out),
    .last  (out_ch.last_out)
  );

endmodule

FILE: design/hca_checker.sv
// ----------------------------------------------------------------------------
// hca_checker: port-level checks for hsv_color_adjust
// Watches the handshakes of the pipeline and the configuration port.
// ----------------------------------------------------------------------------
module hca_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty or draining output never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked while output flows");

  // configuration writes always complete at once
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind hsv_color_adjust hca_checker u_hca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_ready (cfg_ch.ready)
);

FILE: test/hsv_color_adjust_tb.sv
// ----------------------------------------------------------------------------
// hsv_color_adjust_tb: self-checking bench for the HSV color adjust pipeline
// Drives pixels with random gaps, predicts each adjusted pixel in fixed point
// and compares every output transaction in order against the prediction.
// ----------------------------------------------------------------------------
module hsv_color_adjust_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;

  hca_pix_in_if  in_ch();
  hca_pix_out_if out_ch();
  hca_cfg_if     cfg_ch();

  hsv_color_adjust dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Shadow copy of the block's registers
  logic [15:0] hue_shift_q;
  logic [15:0] sat_gain_q;
  logic [15:0] val_gain_q;

  pixel_t adjusted_q[$];
  int     mismatch_cnt;
  int     pixels_sent;
  int     pixels_checked;
  int     cfg_writes;
  int     cycle_cnt;
  bit     hold_off_long;   // receiver holds ready low once this is set, then releases it
  bit     out_random;      // receiver draws random gaps while set

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the cycle counter and stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Clamp a Q4.12 gain product to 1.0
  function automatic logic [16:0] gain_clamp(logic [16:0] x, logic [15:0] gain);
    logic [63:0] p;
    p = (64'(x) * 64'(gain)) >> 12;
    return (p > 64'(hca_pkg::ONE_Q16)) ? hca_pkg::ONE_Q16 : p[16:0];
  endfunction

  function automatic logic [7:0] q16_to_byte(logic [31:0] q);
    logic [63:0] p;
    p = (64'(q) * 64'd255) >> 16;
    return p[7:0];
  endfunction

  // Predict the adjusted pixel from the current register shadow
  function automatic pixel_t adjust_pixel(pixel_t px);
    logic [31:0] r, g, b, mx, mn, d, num, hue, sat, val, c, x, m, p, f, sec;
    logic [31:0] q0, q1, q2;
    pixel_t res;
    r = px.red; g = px.green; b = px.blue;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    d = mx - mn;
    val = (mx * 32'd65536 + 32'd254) / 32'd255;
    sat = (mx == 0) ? 32'd0 : (d * 32'd65536) / mx;
    if (d == 0) begin
      hue = 0;
    end else begin
      if (mx == r) num = (g >= b) ? (g - b) : (6 * d - (b - g));
      else if (mx == g) num = 2 * d + b - r;
      else num = 4 * d + r - g;
      hue = 32'((64'(num) * 64'd65536) / 64'(6 * d));
    end
    hue = (hue + hue_shift_q) & 32'hFFFF;
    sat = gain_clamp(sat[16:0], sat_gain_q);
    val = gain_clamp(val[16:0], val_gain_q);
    c = 32'((64'(val) * 64'(sat)) >> 16);
    p = hue * 6;
    sec = p >> 16;
    f = p & 32'hFFFF;
    if (!sec[0]) x = 32'((64'(c) * 64'(f)) >> 16);
    else x = 32'((64'(c) * 64'(32'd65536 - f)) >> 16);
    m = val - c;
    case (sec)
      0: begin q0 = c; q1 = x; q2 = 0; end
      1: begin q0 = x; q1 = c; q2 = 0; end
      2: begin q0 = 0; q1 = c; q2 = x; end
      3: begin q0 = 0; q1 = x; q2 = c; end
      4: begin q0 = x; q1 = 0; q2 = c; end
      default: begin q0 = c; q1 = 0; q2 = x; end
    endcase
    res.red   = q16_to_byte(q0 + m);
    res.green = q16_to_byte(q1 + m);
    res.blue  = q16_to_byte(q2 + m);
    res.alpha = px.alpha;
    res.last  = px.last;
    return res;
  endfunction

  // Send one pixel after a random gap and queue its prediction on acceptance
  task automatic send_pixel(pixel_t px, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;   // keep back-to-back stretches
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.red_in     <= px.red;
    in_ch.green_in   <= px.green;
    in_ch.blue_in    <= px.blue;
    in_ch.alpha_in   <= px.alpha;
    in_ch.last_pixel <= px.last;
    do @(posedge clk); while (!in_ch.ready);
    adjusted_q.push_back(adjust_pixel(px));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  // Wait for every prediction to be matched, then let the pipe drain
  task automatic wait_drained();
    drop_valid();
    while (adjusted_q.size() != 0) @(negedge clk);
    repeat (hca_pkg::NUM_STAGES + 4) @(negedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(logic [hca_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      hca_pkg::CFG_HUE_OFFSET: hue_shift_q = data;
      hca_pkg::CFG_SAT_GAIN:   sat_gain_q  = data;
      hca_pkg::CFG_VAL_GAIN:   val_gain_q  = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_gains(logic [15:0] hue, logic [15:0] sat, logic [15:0] val);
    write_reg(hca_pkg::CFG_HUE_OFFSET, hue);
    write_reg(hca_pkg::CFG_SAT_GAIN, sat);
    write_reg(hca_pkg::CFG_VAL_GAIN, val);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px = pixel_t'($urandom());
    px.last = ($urandom_range(0, 15) == 0);
    return px;
  endfunction

  // Extremes, grays, black, primaries and ties at reset settings
  task automatic test_directed_pixels();
    pixel_t list[$];
    list = '{
      {8'd0, 8'd0, 8'd0, 8'd0, 1'b0},         // black
      {8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, // white
      {8'd128, 8'd128, 8'd128, 8'd77, 1'b0},  // gray
      {8'd255, 8'd0, 8'd0, 8'd1, 1'b0},
      {8'd0, 8'd255, 8'd0, 8'd2, 1'b0},
      {8'd0, 8'd0, 8'd255, 8'd4, 1'b0},
      {8'd200, 8'd200, 8'd10, 8'd8, 1'b0},    // red/green tie
      {8'd30, 8'd220, 8'd220, 8'd16, 1'b0},   // green/blue tie
      {8'd180, 8'd20, 8'd180, 8'd32, 1'b0},   // red/blue tie
      {8'd255, 8'd10, 8'd200, 8'd64, 1'b0},   // red max, blue above green
      {8'd1, 8'd0, 8'd0, 8'd128, 1'b0},
      {8'd170, 8'd85, 8'd42, 8'd170, 1'b0},
      {8'd85, 8'd170, 8'd255, 8'd85, 1'b1}
    };
    foreach (list[i]) send_pixel(list[i]);
    wait_drained();
  endtask

  // Hue wrap, gains above 1.0, zero gains and an ignored register index
  task automatic test_register_extremes();
    logic [15:0] hues[4];
    hues = '{16'hFFFF, 16'h8000, 16'h2AAB, 16'hF000};
    foreach (hues[i]) begin
      set_gains(hues[i], (i % 2) ? 16'hFFFF : 16'h0000, (i < 2) ? 16'hFFFF : 16'h0800);
      write_reg(8'd3 + i[7:0], 16'hFFFF);   // beyond the last register: dropped
      repeat (6) send_pixel(rand_pixel());
      send_pixel('{8'd255, 8'd0, 8'd0, 8'd9, 1'b1});
      wait_drained();
    end
    write_reg(8'hFF, 16'h1234);
  endtask

  // Random pixels across a series of random register settings
  task automatic test_random_stream(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 250 == 0) begin
        wait_drained();
        set_gains(16'($urandom()), 16'($urandom_range(0, 12288)),
                  16'($urandom_range(0, 12288)));
      end
      send_pixel(rand_pixel());
    end
    wait_drained();
  endtask

  // Hold the receiver off while pixels keep coming so the input stalls
  task automatic test_backpressure();
    hold_off_long = 1'b1;
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel(), 1'b0);
    hold_off_long = 1'b0;
    wait_drained();
  endtask

  // Receiver: random ready, a long hold-off counted in its own process
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_long) begin
        out_ch.ready <= 1'b0;
        stall = 0;
        while (stall < 60) begin
          @(negedge clk);
          stall++;
        end
        out_ch.ready <= 1'b1;
        wait (!hold_off_long);
      end else if (out_random && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check each output transaction against the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (adjusted_q.size() == 0) begin
        $display("%0t: expected no pixel, got r=%0d g=%0d b=%0d", $time,
                 out_ch.red_out, out_ch.green_out, out_ch.blue_out);
        mismatch_cnt++;
      end else begin
        want = adjusted_q.pop_front();
        pixels_checked++;
        if (out_ch.red_out !== want.red || out_ch.green_out !== want.green ||
            out_ch.blue_out !== want.blue || out_ch.alpha_out !== want.alpha ||
            out_ch.last_out !== want.last) begin
          $display("%0t: expected rgba=%h %h %h %h last=%b, got %h %h %h %h last=%b",
                   $time, want.red, want.green, want.blue, want.alpha, want.last,
                   out_ch.red_out, out_ch.green_out, out_ch.blue_out,
                   out_ch.alpha_out, out_ch.last_out);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    in_ch.alpha_in = '0;
    in_ch.last_pixel = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    hue_shift_q = hca_pkg::HUE_OFFSET_RST;
    sat_gain_q = hca_pkg::GAIN_UNITY;
    val_gain_q = hca_pkg::GAIN_UNITY;
    mismatch_cnt = 0;
    pixels_sent = 0;
    pixels_checked = 0;
    cfg_writes = 0;
    cycle_cnt = 0;
    hold_off_long = 1'b0;
    out_random = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_pixels();
    out_random = 1'b1;
    test_register_extremes();
    test_backpressure();
    test_random_stream(2000);
    set_gains(hca_pkg::HUE_OFFSET_RST, hca_pkg::GAIN_UNITY, hca_pkg::GAIN_UNITY);
    out_random = 1'b0;
    test_random_stream(100);

    $display("Checked %0d of %0d pixels over %0d register writes,", pixels_checked,
             pixels_sent, cfg_writes);
    $display("with hue wrap, gain clamps, ties, gray and black pixels and stalls.");
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
